@@ src/rth_pkg.sv @@
// rth_pkg: shared constants and types for the rgb to hue pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package rth_pkg;

    // default channel width
    localparam int CHANNEL_BITS_DEF = 8;

    // quotient width of the divider, enough for hues 0..360
    localparam int QUOT_BITS = 9;

    // width of the hue output
    localparam int HUE_BITS = 9;

    // full circle in degrees
    localparam int HUE_WRAP = 360;

    // sector scale and offsets in degrees
    localparam int SECTOR_SCALE  = 60;
    localparam int GREEN_OFFSET  = 120;
    localparam int BLUE_OFFSET   = 240;

    // which channel holds the maximum
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

endpackage

`default_nettype wire

@@ src/rth_sort.sv @@
// rth_sort: first pipeline stage, finds max/min channel, range and sector difference
// depends on rth_pkg
`default_nettype none

module rth_sort
    import rth_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire logic                           i_valid,
    input  wire logic        [CHANNEL_BITS-1:0] i_red,
    input  wire logic        [CHANNEL_BITS-1:0] i_green,
    input  wire logic        [CHANNEL_BITS-1:0] i_blue,
    output logic                                o_valid,
    output t_sector                             o_sector,
    output logic             [CHANNEL_BITS-1:0] o_range,
    output logic signed      [CHANNEL_BITS:0]   o_diff
);

    logic                           r_valid;
    t_sector                        r_sector;
    logic        [CHANNEL_BITS-1:0] r_range;
    logic signed [CHANNEL_BITS:0]   r_diff;

    t_sector                        n_sector;
    logic        [CHANNEL_BITS-1:0] n_range;
    logic signed [CHANNEL_BITS:0]   n_diff;
    logic        [CHANNEL_BITS-1:0] w_max;
    logic        [CHANNEL_BITS-1:0] w_min;

    // sector pick: red wins ties, then green
    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_sector = SEC_RED;
            w_max    = i_red;
            n_diff   = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            n_sector = SEC_GREEN;
            w_max    = i_green;
            n_diff   = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_sector = SEC_BLUE;
            w_max    = i_blue;
            n_diff   = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    // smallest channel and range
    always_comb begin
        w_min = i_red;
        if (i_green < w_min) begin
            w_min = i_green;
        end
        if (i_blue < w_min) begin
            w_min = i_blue;
        end
        n_range = w_max - w_min;
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sector <= n_sector;
            r_range  <= n_range;
            r_diff   <= n_diff;
        end
    end

    assign o_valid  = r_valid;
    assign o_sector = r_sector;
    assign o_range  = r_range;
    assign o_diff   = r_diff;

endmodule

`default_nettype wire

@@ src/rth_numer.sv @@
// rth_numer: second pipeline stage, forms the rounded dividend and the divisor
// depends on rth_pkg
`default_nettype none

module rth_numer
    import rth_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire logic                           i_valid,
    input  wire t_sector                        i_sector,
    input  wire logic        [CHANNEL_BITS-1:0] i_range,
    input  wire logic signed [CHANNEL_BITS:0]   i_diff,
    output logic                                o_valid,
    output logic             [CHANNEL_BITS+9:0] o_rem,
    output logic             [CHANNEL_BITS:0]   o_den
);

    localparam int XW = CHANNEL_BITS + 10;
    localparam int DW = CHANNEL_BITS + 1;
    localparam int NW = CHANNEL_BITS + 11;

    localparam logic signed [NW-1:0] K_SCALE = NW'(SECTOR_SCALE);
    localparam logic signed [NW-1:0] K_WRAP  = NW'(HUE_WRAP);
    localparam logic signed [NW-1:0] K_GREEN = NW'(GREEN_OFFSET);
    localparam logic signed [NW-1:0] K_BLUE  = NW'(BLUE_OFFSET);

    logic          r_valid;
    logic [XW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic signed [NW-1:0] w_diff_x;
    logic signed [NW-1:0] w_range_x;
    logic signed [NW-1:0] w_offset;
    logic signed [NW-1:0] w_num;
    logic signed [NW-1:0] w_dividend;
    logic        [XW-1:0] n_rem;
    logic        [DW-1:0] n_den;

    assign w_diff_x  = NW'(i_diff);
    assign w_range_x = $signed({{(NW-CHANNEL_BITS){1'b0}}, i_range});

    // sector offset, red wraps negative hues
    always_comb begin
        case (i_sector)
            SEC_RED:   w_offset = (i_diff < 0) ? K_WRAP : '0;
            SEC_GREEN: w_offset = K_GREEN;
            SEC_BLUE:  w_offset = K_BLUE;
            default:   w_offset = '0;
        endcase
    end

    // numerator and round-half-up dividend 2n + d
    always_comb begin
        w_num      = NW'(w_diff_x * K_SCALE) + NW'(w_offset * w_range_x);
        w_dividend = (w_num <<< 1) + w_range_x;
        n_rem      = w_dividend[XW-1:0];
        // grey pixel: dividend is zero, divisor forced nonzero so quotient is zero
        if (i_range == '0) begin
            n_den = DW'(2);
        end else begin
            n_den = {i_range, 1'b0};
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= n_rem;
            r_den <= n_den;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;

endmodule

`default_nettype wire

@@ src/rth_div_step.sv @@
// rth_div_step: one registered step of the restoring divider, resolves one quotient bit
// depends on rth_pkg
`default_nettype none

module rth_div_step
    import rth_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    parameter int STEP         = 0
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire logic                      i_valid,
    input  wire logic [CHANNEL_BITS+9:0]   i_rem,
    input  wire logic [CHANNEL_BITS:0]     i_den,
    input  wire logic [QUOT_BITS-1:0]      i_quot,
    output logic                           o_valid,
    output logic      [CHANNEL_BITS+9:0]   o_rem,
    output logic      [CHANNEL_BITS:0]     o_den,
    output logic      [QUOT_BITS-1:0]      o_quot
);

    localparam int XW = CHANNEL_BITS + 10;
    localparam int DW = CHANNEL_BITS + 1;

    logic                 r_valid;
    logic [XW-1:0]        r_rem;
    logic [DW-1:0]        r_den;
    logic [QUOT_BITS-1:0] r_quot;

    logic [XW-1:0]        w_shifted;
    logic [XW-1:0]        n_rem;
    logic [QUOT_BITS-1:0] n_quot;

    // trial subtract of the divisor at this bit weight
    always_comb begin
        w_shifted = XW'(i_den) << STEP;
        n_rem     = i_rem;
        n_quot    = i_quot;
        if (i_rem >= w_shifted) begin
            n_rem        = i_rem - w_shifted;
            n_quot[STEP] = 1'b1;
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quot <= n_quot;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quot  = r_quot;

endmodule

`default_nettype wire

@@ src/rgb_to_hue_degrees.sv @@
// rgb_to_hue_degrees: top level, RGB pixel to HSV hue in whole degrees
// depends on rth_pkg, rth_sort, rth_numer, rth_div_step
`default_nettype none

// Converts one RGB pixel per clock into its HSV hue, 0 to 359 degrees, with
// grey pixels giving 0 and the hue rounded half up. The pipeline takes one
// item every cycle unless stalled: one stage sorts the channels, one forms
// the dividend, a restoring divider resolves one quotient bit per stage, and
// an output register holds the result. Each stage holds its item only while
// the stage after it is full and stalled, so empty stages keep filling while
// a result waits; the input stalls only when every stage is occupied.

module rgb_to_hue_degrees
    import rth_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [CHANNEL_BITS-1:0]  i_red,
    input  wire logic [CHANNEL_BITS-1:0]  i_green,
    input  wire logic [CHANNEL_BITS-1:0]  i_blue,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic      [HUE_BITS-1:0]      o_hue_degrees
);

    localparam int XW  = CHANNEL_BITS + 10;
    localparam int DW  = CHANNEL_BITS + 1;
    localparam int NST = QUOT_BITS + 2;

    logic [NST-1:0] w_v;
    logic [NST:0]   w_load;

    t_sector                        w_sector;
    logic        [CHANNEL_BITS-1:0] w_range;
    logic signed [CHANNEL_BITS:0]   w_diff;

    logic [XW-1:0]        w_rem  [0:QUOT_BITS];
    logic [DW-1:0]        w_den  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] w_quot [0:QUOT_BITS];

    logic                r_valid;
    logic [HUE_BITS-1:0] r_hue;
    logic [HUE_BITS-1:0] n_hue;

    // per-stage load: a stage moves when empty or when the next one moves
    assign w_load[NST] = !r_valid || !i_stall;
    for (genvar k = 0; k < NST; k++) begin : g_load
        assign w_load[k] = !w_v[k] || w_load[k+1];
    end

    assign o_stall = !w_load[0];

    // channel sort
    rth_sort #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_sort (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load[0]),
        .i_valid  (i_valid),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .o_valid  (w_v[0]),
        .o_sector (w_sector),
        .o_range  (w_range),
        .o_diff   (w_diff)
    );

    // dividend and divisor
    rth_numer #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_numer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load[1]),
        .i_valid  (w_v[0]),
        .i_sector (w_sector),
        .i_range  (w_range),
        .i_diff   (w_diff),
        .o_valid  (w_v[1]),
        .o_rem    (w_rem[0]),
        .o_den    (w_den[0])
    );

    assign w_quot[0] = '0;

    // divider, most significant quotient bit first
    for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
        rth_div_step #(
            .CHANNEL_BITS (CHANNEL_BITS),
            .STEP         (QUOT_BITS - 1 - j)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load[j+2]),
            .i_valid (w_v[j+1]),
            .i_rem   (w_rem[j]),
            .i_den   (w_den[j]),
            .i_quot  (w_quot[j]),
            .o_valid (w_v[j+2]),
            .o_rem   (w_rem[j+1]),
            .o_den   (w_den[j+1]),
            .o_quot  (w_quot[j+1])
        );
    end

    // a hue that rounds to a full circle reads as zero
    assign n_hue = (w_quot[QUOT_BITS] == QUOT_BITS'(HUE_WRAP)) ? '0
                                                              : HUE_BITS'(w_quot[QUOT_BITS]);

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load[NST]) begin
            r_valid <= w_v[NST-1];
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load[NST]) begin
            r_hue <= n_hue;
        end
    end

    assign o_valid       = r_valid;
    assign o_hue_degrees = r_hue;

    // hue stays inside the circle
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue_degrees < HUE_BITS'(HUE_WRAP)))
        else $error("hue out of range");

    // input stalls only with every stage full and the output blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&w_v) && r_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    // a finished item leaving the divider lands in the output register
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v[NST-1] && w_load[NST]) |=> o_valid)
        else $error("item lost at the output register");

endmodule

`default_nettype wire

@@ sim/tb_rgb_to_hue_degrees.sv @@
// tb_rgb_to_hue_degrees: self-checking bench for the rgb to hue pipeline
// depends on rth_pkg and rgb_to_hue_degrees; predicts each hue in integer math
`default_nettype none

module tb_rgb_to_hue_degrees
    import rth_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAN_BITS      = CHANNEL_BITS_DEF;
    localparam int HOLD_CYCLES    = 80;
    localparam int TAIL_CYCLES    = 24;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } t_pixel;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 i_stall = 1'b0;
    logic [CHAN_BITS-1:0] i_red   = '0;
    logic [CHAN_BITS-1:0] i_green = '0;
    logic [CHAN_BITS-1:0] i_blue  = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [HUE_BITS-1:0]  o_hue_degrees;

    t_pixel              pixel_queue[$];
    logic [HUE_BITS-1:0] expected_hues[$];
    logic                pixel_taken   = 1'b0;
    int                  hue_errors    = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  hold_req      = 0;
    int                  hold_started  = 0;
    int                  hold_left     = 0;
    int                  quiet_cycles  = 0;

    rgb_to_hue_degrees u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hue_degrees (o_hue_degrees)
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // hue in whole degrees, rounded half up, grey gives zero
    function automatic logic [HUE_BITS-1:0] hue_of_pixel(t_pixel px);
        int      r;
        int      g;
        int      b;
        int      hi;
        int      lo;
        int      span;
        int      numer;
        t_sector sector;
        r  = px.red;
        g  = px.green;
        b  = px.blue;
        hi = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
        lo = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
        span = hi - lo;
        if (span == 0) begin
            return '0;
        end
        // red wins every tie for the max, then green
        if (r == hi) begin
            sector = SEC_RED;
        end else if (g == hi) begin
            sector = SEC_GREEN;
        end else begin
            sector = SEC_BLUE;
        end
        case (sector)
            SEC_RED: begin
                numer = SECTOR_SCALE * (g - b);
                if (numer < 0) begin
                    numer += HUE_WRAP * span;
                end
            end
            SEC_GREEN: begin
                numer = SECTOR_SCALE * (b - r) + GREEN_OFFSET * span;
            end
            default: begin
                numer = SECTOR_SCALE * (r - g) + BLUE_OFFSET * span;
            end
        endcase
        return HUE_BITS'(((2 * numer + span) / (2 * span)) % HUE_WRAP);
    endfunction

    // random pixel, biased toward ties, near-grey and extreme channels
    function automatic t_pixel random_pixel();
        t_pixel               px;
        logic [CHAN_BITS-1:0] v[3];
        logic [CHAN_BITS-1:0] t;
        int                   i;
        for (i = 0; i < 3; i++) begin
            v[i] = CHAN_BITS'($urandom);
        end
        case ($urandom_range(9))
            4: begin
                v[1] = v[0];
            end
            5: begin
                v[1] = v[0] ^ CHAN_BITS'($urandom_range(3));
                v[2] = v[0] ^ CHAN_BITS'($urandom_range(3));
            end
            6: begin
                for (i = 0; i < 3; i++) begin
                    case ($urandom_range(4))
                        0: v[i] = '0;
                        1: v[i] = '1;
                        2: v[i] = CHAN_BITS'(1);
                        3: v[i] = ~CHAN_BITS'(1);
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        // three random swaps reach every channel order
        if ($urandom_range(1)) begin
            t = v[0]; v[0] = v[1]; v[1] = t;
        end
        if ($urandom_range(1)) begin
            t = v[1]; v[1] = v[2]; v[2] = t;
        end
        if ($urandom_range(1)) begin
            t = v[0]; v[0] = v[1]; v[1] = t;
        end
        px.red   = v[0];
        px.green = v[1];
        px.blue  = v[2];
        return px;
    endfunction

    // append one item to the pending queue
    task automatic enqueue_pixel(t_pixel px);
        pixel_queue.insert(pixel_queue.size(), px);
    endtask

    task automatic queue_pixel(int r, int g, int b);
        t_pixel px;
        px.red   = CHAN_BITS'(r);
        px.green = CHAN_BITS'(g);
        px.blue  = CHAN_BITS'(b);
        enqueue_pixel(px);
    endtask

    // sender stays quiet until every item is out and every hue is back
    task automatic wait_for_drain();
        while (pixel_queue.size() != 0 || i_valid || expected_hues.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // driver: next item at the falling edge, stalled item held
    always @(negedge i_clk) begin
        t_pixel px;
        if (!(i_valid && !pixel_taken)) begin
            if (i_rst_n && pixel_queue.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                px = pixel_queue.pop_front();
                i_red   <= px.red;
                i_green <= px.green;
                i_blue  <= px.blue;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_started != hold_req) begin
            hold_started <= hold_req;
            hold_left    <= HOLD_CYCLES;
            i_stall      <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: check each hue against the oldest prediction
    always @(posedge i_clk) begin
        logic [HUE_BITS-1:0] want;
        if (i_rst_n) begin
            if ($isunknown(o_valid)) begin
                $error("o_valid unknown after reset");
                hue_errors++;
            end else if (o_valid && !i_stall) begin
                if (expected_hues.size() == 0) begin
                    $error("hue_degrees: item with no pixel pending, actual %0d",
                           o_hue_degrees);
                    hue_errors++;
                end else begin
                    want = expected_hues.pop_front();
                    if (o_hue_degrees !== want) begin
                        $error("hue_degrees mismatch: expected %0d, actual %0d",
                               want, o_hue_degrees);
                        hue_errors++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                expected_hues.insert(expected_hues.size(),
                                     hue_of_pixel(t_pixel'({i_red, i_green, i_blue})));
            end
        end
        pixel_taken <= i_rst_n && i_valid && !o_stall;
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("rgb_to_hue_degrees test failed");
            $finish;
        end
    end

    // stimulus and phase sequencing
    initial begin
        int i;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 32;
        recv_idle_pct = 62;

        // grey pixels
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(128, 128, 128);
        // primaries and secondaries, ties for the max
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        queue_pixel(255, 255, 0);
        queue_pixel(0, 255, 255);
        queue_pixel(255, 0, 255);
        // negative red hue, one rounding up to 360
        queue_pixel(255, 0, 1);
        queue_pixel(255, 0, 254);
        queue_pixel(200, 100, 150);
        queue_pixel(255, 1, 0);
        // exact half-degree, rounds up
        queue_pixel(120, 1, 0);
        // smallest spread, then two wide-spread pixels
        queue_pixel(1, 0, 0);
        queue_pixel(0, 1, 0);
        queue_pixel(0, 0, 1);
        queue_pixel(1, 0, 1);
        queue_pixel(255, 254, 255);
        queue_pixel(254, 255, 254);
        queue_pixel(255, 254, 0);
        queue_pixel(85, 170, 255);
        for (i = 0; i < 680; i++) begin
            enqueue_pixel(random_pixel());
        end
        wait_for_drain();

        // roles swapped
        send_idle_pct = 62;
        recv_idle_pct = 32;
        for (i = 0; i < 700; i++) begin
            enqueue_pixel(random_pixel());
        end
        wait_for_drain();

        // no idling, with a long receiver hold-off to fill the pipe
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req++;
        for (i = 0; i < 600; i++) begin
            enqueue_pixel(random_pixel());
        end
        wait_for_drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (hue_errors == 0 && expected_hues.size() == 0) begin
            $display("rgb_to_hue_degrees test passed");
        end else begin
            $display("rgb_to_hue_degrees test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
